### rtl/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/npps_pkg.sv
`timescale 1ns / 1ps

package npps_pkg;

  localparam int MAX_PROCS = 16;
  localparam int ID_W      = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);

  localparam int ARR_W     = 16;
  localparam int PRIO_W    = 8;
  localparam int BURST_W   = 16;
  localparam int CLK_W     = 21;
  localparam int PROC_ID_W = 4;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_START = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [ARR_W-1:0]   arrival_time;
    logic [PRIO_W-1:0]  priority_req;
    logic [BURST_W-1:0] burst_time;
  } in_req_t;

  typedef struct packed {
    logic [PROC_ID_W-1:0] proc_id;
    logic [CLK_W-1:0]     start_time;
    logic [CLK_W-1:0]     finish_time;
    logic                 empty_run;
    logic                 last;
  } out_res_t;

  // running candidates passed down the cell row
  // a: best already-arrived entry, b: best entry among the earliest arrivals
  typedef struct packed {
    logic               a_vld;
    logic [PRIO_W-1:0]  a_prio;
    logic [ID_W-1:0]    a_id;
    logic [BURST_W-1:0] a_burst;
    logic               b_vld;
    logic [ARR_W-1:0]   b_arr;
    logic [PRIO_W-1:0]  b_prio;
    logic [ID_W-1:0]    b_id;
    logic [BURST_W-1:0] b_burst;
  } cand_t;

  typedef struct packed {
    logic wr_en;
    logic clr_en;
  } cell_ctl_t;

endpackage

### rtl/nonpreemptive_priority_scheduler.sv
`timescale 1ns / 1ps

// Non-preemptive priority scheduler over a row of MAX_PROCS cells, one per
// process. A load request fills the next free cell; loads
// past MAX_PROCS are dropped. A start request runs the whole schedule from
// time zero: the selection ripples down the cell row one cell per cycle, and
// each dispatch is made once the scan has passed every cell and the output
// is not stalled. A start with no loaded process returns one result with
// empty_run set. Input requests are stalled while a run is in progress.

`include "assert_macros.svh"

module nonpreemptive_priority_scheduler import npps_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_res_t out_res_o
);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   scan_cnt_q;
  logic [CNT_W-1:0]   count_q;
  logic [CLK_W-1:0]   clk_now_q;
  logic               out_valid_q;
  out_res_t           out_q;

  cand_t              chain [MAX_PROCS+1];
  cell_ctl_t          ctl   [MAX_PROCS];
  logic [MAX_PROCS-1:0] pend_vec;
  logic [MAX_PROCS-1:0] pick_mask;

  cand_t              tail;
  logic               in_acc;
  logic               do_load;
  logic               do_start;
  logic               scan_done;
  logic               out_free;
  logic               emit;
  logic               pend_any;
  logic               use_a;
  logic [ID_W-1:0]    pick_id;
  logic [BURST_W-1:0] pick_burst;
  logic [CLK_W-1:0]   start_t;
  logic [CLK_W-1:0]   finish_t;
  logic               last_disp;
  out_res_t           res_d;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign do_load    = in_acc && (in_req_i.req_type == REQ_LOAD) &&
                      (count_q < CNT_W'(MAX_PROCS));
  assign do_start   = in_acc && (in_req_i.req_type == REQ_START);

  assign chain[0] = '0;

  for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
    assign ctl[i].wr_en  = do_load && (count_q[ID_W-1:0] == ID_W'(i));
    assign ctl[i].clr_en = emit && pend_any && (pick_id == ID_W'(i));

    npps_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl[i]),
      .cell_id_i  (ID_W'(i)),
      .wr_arr_i   (in_req_i.arrival_time),
      .wr_prio_i  (in_req_i.priority_req),
      .wr_burst_i (in_req_i.burst_time),
      .clk_now_i  (clk_now_q),
      .cand_i     (chain[i]),
      .cand_o     (chain[i+1]),
      .pend_o     (pend_vec[i])
    );
  end

  assign tail      = chain[MAX_PROCS];
  assign pend_any  = |pend_vec;
  assign scan_done = (state_q == ST_SCAN) && (scan_cnt_q == CNT_W'(MAX_PROCS));
  assign out_free  = !out_valid_q || !out_stall_i;
  assign emit      = scan_done && out_free;

  // nothing arrived yet: the clock jumps to the earliest arrival
  assign use_a      = tail.a_vld;
  assign pick_id    = use_a ? tail.a_id : tail.b_id;
  assign pick_burst = use_a ? tail.a_burst : tail.b_burst;
  assign start_t    = use_a ? clk_now_q : CLK_W'(tail.b_arr);
  assign finish_t   = start_t + CLK_W'(pick_burst);
  assign pick_mask  = MAX_PROCS'(1) << pick_id;
  assign last_disp  = ((pend_vec & ~pick_mask) == '0);

  always_comb begin
    res_d = '0;
    if (pend_any) begin
      res_d.proc_id     = PROC_ID_W'(pick_id);
      res_d.start_time  = start_t;
      res_d.finish_time = finish_t;
      res_d.last        = last_disp;
    end else begin
      res_d.empty_run = 1'b1;
      res_d.last      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_cnt_q  <= '0;
      count_q     <= '0;
      clk_now_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (do_load) begin
            count_q <= count_q + CNT_W'(1);
          end
          if (do_start) begin
            state_q    <= ST_SCAN;
            scan_cnt_q <= '0;
            clk_now_q  <= '0;
          end
        end
        ST_SCAN: begin
          if (!scan_done) begin
            scan_cnt_q <= scan_cnt_q + CNT_W'(1);
          end else if (emit) begin
            scan_cnt_q  <= '0;
            clk_now_q   <= finish_t;
            if (res_d.last) begin
              state_q <= ST_IDLE;
              count_q <= '0;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  `ASSERT_IMPL(a_scan_finds_pick, clk_i, rst_ni, scan_done && pend_any,
               tail.a_vld || tail.b_vld)
  `ASSERT_NEXT(a_dispatch_clears_one, clk_i, rst_ni, emit && pend_any,
               $countones(pend_vec) == $past($countones(pend_vec)) - 1)
  `ASSERT_IMPL(a_empty_is_last, clk_i, rst_ni, out_valid_o && out_res_o.empty_run,
               out_res_o.last)
  `ASSERT_IMPL(a_idle_empty_table, clk_i, rst_ni,
               (state_q == ST_IDLE) && (count_q == '0), pend_vec == '0)

endmodule

### rtl/npps_cell.sv
`timescale 1ns / 1ps

module npps_cell import npps_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cell_ctl_t          ctl_i,
  input  logic [ID_W-1:0]    cell_id_i,
  input  logic [ARR_W-1:0]   wr_arr_i,
  input  logic [PRIO_W-1:0]  wr_prio_i,
  input  logic [BURST_W-1:0] wr_burst_i,
  input  logic [CLK_W-1:0]   clk_now_i,
  input  cand_t              cand_i,
  output cand_t              cand_o,
  output logic               pend_o
);

  logic [ARR_W-1:0]   arr_q;
  logic [PRIO_W-1:0]  prio_q;
  logic [BURST_W-1:0] burst_q;
  logic               pend_q;
  cand_t              cand_d;
  cand_t              cand_q;
  logic               arrived;
  logic               take_a;
  logic               take_b;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      arr_q   <= wr_arr_i;
      prio_q  <= wr_prio_i;
      burst_q <= wr_burst_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      cand_q <= '0;
    end else begin
      if (ctl_i.wr_en) begin
        pend_q <= 1'b1;
      end else if (ctl_i.clr_en) begin
        pend_q <= 1'b0;
      end
      cand_q <= cand_d;
    end
  end

  assign arrived = pend_q && (CLK_W'(arr_q) <= clk_now_i);
  // strict compares keep the lower id on ties
  assign take_a  = arrived && (!cand_i.a_vld || (prio_q < cand_i.a_prio));
  assign take_b  = pend_q && (!cand_i.b_vld || (arr_q < cand_i.b_arr) ||
                   ((arr_q == cand_i.b_arr) && (prio_q < cand_i.b_prio)));

  always_comb begin
    cand_d = cand_i;
    if (take_a) begin
      cand_d.a_vld   = 1'b1;
      cand_d.a_prio  = prio_q;
      cand_d.a_id    = cell_id_i;
      cand_d.a_burst = burst_q;
    end
    if (take_b) begin
      cand_d.b_vld   = 1'b1;
      cand_d.b_arr   = arr_q;
      cand_d.b_prio  = prio_q;
      cand_d.b_id    = cell_id_i;
      cand_d.b_burst = burst_q;
    end
  end

  assign cand_o = cand_q;
  assign pend_o = pend_q;

endmodule
